/* hw/rtl/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants and controller/datapath interface types for the
// sorted-table binary search.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 1024;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 10;
    localparam int USED_W  = 11;
    localparam int PROBE_W = 5;

    localparam logic [USED_W-1:0] USED_RESET = 11'd1024;

    // operation codes carried in s_tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;        // write table entry from the input transfer
        logic start;        // load key and initial span, read first middle
        logic step;         // narrow span, count a probe, read new middle
        logic check_hi;     // read upper entry of a two-entry span
        logic finish;       // capture result
        logic finish_found;
        logic finish_hi;    // matching position is hi rather than mid
        logic load_out;     // move result into the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;          // entry read equals key
        logic less;         // entry read is below key
        logic span_one;
        logic span_two;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a loadable table of ascending signed 32-bit keys.
// ----------------------------------------------------------------------------
// Write transfers (s_tuser = 0) store one key per cycle and produce no result.
// A search transfer (s_tuser = 1) is accepted, then probes one middle entry
// at a time, reads the upper entry as well when the span ends at two entries
// and the lower one misses, and moves the result into the output register
// once that register is free: with 1024 entries at most 11 probes. The search
// is paced by the key memory, which delivers one registered entry per cycle
// to the comparator. No new transfer is taken while a search runs;
// a finished result may wait in the output register while the next transfer
// is accepted. The table has no reset; entries must be written before they
// are searched. used_entries is clamped to 1..TABLE_DEPTH.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,   // used_entries
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,       // entry_index[9:0], key_value[41:10]
    input  wire logic [0:0]  s_tuser,       // operation[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // position[9:0], probe_count[14:10]
    output logic [0:0]       m_tuser        // found[0]
);

    stbs_pkg::dp_cmd_t    cmd;
    stbs_pkg::dp_status_t status;

    logic                                   out_found;
    logic [stbs_pkg::INDEX_W-1:0]           out_position;
    logic [stbs_pkg::PROBE_W-1:0]           out_probe_count;

    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_entry_index  (s_tdata[9:0]),
        .in_key_value    (s_tdata[41:10]),
        .out_found       (out_found),
        .out_position    (out_position),
        .out_probe_count (out_probe_count)
    );

    assign m_tdata = {1'b0, out_probe_count, out_position};
    assign m_tuser = out_found;

    // a search keeps the input side closed on the following cycle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == stbs_pkg::OP_SEARCH) |=> !s_tready)
        else $error("input accepted while a search is running");

    // every delivered result counts at least one probe
    a_probe_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:10] != 5'd0))
        else $error("result with zero probe count");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[9:0] == 10'd0))
        else $error("miss with nonzero position");

    // the output register is loaded only when it is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

/* hw/rtl/stbs_datapath.sv */
// ----------------------------------------------------------------------------
// stbs_datapath
// Key table memory, span registers, comparator, probe counter and result
// registers of the binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire stbs_pkg::dp_cmd_t                 cmd,
    output stbs_pkg::dp_status_t                   status,
    input  wire logic                              cfg_wr_en,
    input  wire logic [stbs_pkg::USED_W-1:0]       cfg_wr_data,
    input  wire logic [stbs_pkg::INDEX_W-1:0]      in_entry_index,
    input  wire logic signed [stbs_pkg::KEY_W-1:0] in_key_value,
    output logic                                   out_found,
    output logic [stbs_pkg::INDEX_W-1:0]           out_position,
    output logic [stbs_pkg::PROBE_W-1:0]           out_probe_count
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic signed [stbs_pkg::KEY_W-1:0] mem [TABLE_DEPTH];

    logic [stbs_pkg::USED_W-1:0]       used_reg;
    logic signed [stbs_pkg::KEY_W-1:0] key_reg;
    logic signed [stbs_pkg::KEY_W-1:0] rd_data_reg;
    logic [AW-1:0]                     lo_reg, hi_reg, mid_reg;
    logic [stbs_pkg::PROBE_W-1:0]      probe_reg;
    logic                              res_found_reg;
    logic [stbs_pkg::INDEX_W-1:0]      res_pos_reg;
    logic [stbs_pkg::PROBE_W-1:0]      res_probe_reg;

    logic [AW-1:0] last_idx;
    logic [AW-1:0] start_mid;
    logic [AW-1:0] mid_up, mid_dn;
    logic [AW-1:0] lo_next, hi_next, mid_next;
    logic [AW-1:0] rd_addr;
    logic          wr_ok;

    // saturate the used count to 1..TABLE_DEPTH
    always_comb begin
        if (used_reg == '0) begin
            last_idx = '0;
        end else if (32'(used_reg) >= TABLE_DEPTH) begin
            last_idx = AW'(TABLE_DEPTH - 1);
        end else begin
            last_idx = AW'(used_reg - 1'b1);
        end
    end

    assign start_mid = last_idx >> 1;
    assign mid_up    = mid_reg + ((hi_reg - mid_reg) >> 1);
    assign mid_dn    = lo_reg + ((mid_reg - lo_reg) >> 1);

    // keep the middle entry in whichever half survives
    always_comb begin
        if (status.less) begin
            lo_next  = mid_reg;
            hi_next  = hi_reg;
            mid_next = mid_up;
        end else begin
            lo_next  = lo_reg;
            hi_next  = mid_reg;
            mid_next = mid_dn;
        end
    end

    always_comb begin
        if (cmd.start) begin
            rd_addr = start_mid;
        end else if (cmd.step) begin
            rd_addr = mid_next;
        end else if (cmd.check_hi) begin
            rd_addr = hi_reg;
        end else begin
            rd_addr = mid_reg;
        end
    end

    assign wr_ok = (32'(in_entry_index) < TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wr_ok) begin
            mem[AW'(in_entry_index)] <= in_key_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= stbs_pkg::USED_RESET;
        end else if (cfg_wr_en) begin
            used_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg   <= in_key_value;
            lo_reg    <= '0;
            hi_reg    <= last_idx;
            mid_reg   <= start_mid;
            probe_reg <= stbs_pkg::PROBE_W'(1);
        end else if (cmd.step) begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            probe_reg <= probe_reg + 1'b1;
        end
        if (cmd.finish) begin
            res_found_reg <= cmd.finish_found;
            res_probe_reg <= probe_reg;
            if (!cmd.finish_found) begin
                res_pos_reg <= '0;
            end else if (cmd.finish_hi) begin
                res_pos_reg <= stbs_pkg::INDEX_W'(hi_reg);
            end else begin
                res_pos_reg <= stbs_pkg::INDEX_W'(mid_reg);
            end
        end
        if (cmd.load_out) begin
            out_found       <= res_found_reg;
            out_position    <= res_pos_reg;
            out_probe_count <= res_probe_reg;
        end
    end

    assign status.hit      = (rd_data_reg == key_reg);
    assign status.less     = (rd_data_reg < key_reg);
    assign status.span_one = (hi_reg == lo_reg);
    assign status.span_two = ((hi_reg - lo_reg) == AW'(1));

endmodule

`default_nettype wire

/* hw/rtl/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer of the binary search: accepts transfers, steps the probes and
// hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_op,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output stbs_pkg::dp_cmd_t         cmd,
    input  wire stbs_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PROBE_HI,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == stbs_pkg::OP_SEARCH) begin
                        cmd.start  = 1'b1;
                        state_next = ST_PROBE;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (status.hit) begin
                    cmd.finish       = 1'b1;
                    cmd.finish_found = 1'b1;
                    state_next       = ST_DONE;
                end else if (status.span_two) begin
                    cmd.check_hi = 1'b1;
                    state_next   = ST_PROBE_HI;
                end else if (status.span_one) begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_PROBE_HI: begin
                cmd.finish       = 1'b1;
                cmd.finish_found = status.hit;
                cmd.finish_hi    = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
